[design/byte_stuffed_frame_decoder_core_macros.svh]
// ----------------------------------------------------------------------------
// byte stuffed frame decoder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_DECODER_CORE_MACROS_SVH
`define BYTE_STUFFED_FRAME_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define BSFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bsfd_pkg.sv]
// ----------------------------------------------------------------------------
// bsfd_pkg
// types, codes and defaults of the byte stuffed frame decoder
// ----------------------------------------------------------------------------
package bsfd_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 256;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 9;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DATA  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OK    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CSUM  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PARSE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LONG  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 3'd4;

    localparam logic [BYTE_W-1:0]  START_CODE_RST  = 8'd2;
    localparam logic [BYTE_W-1:0]  END_CODE_RST    = 8'd3;
    localparam logic [BYTE_W-1:0]  ESCAPE_CODE_RST = 8'd27;
    localparam logic [BYTE_W-1:0]  ESCAPE_MASK_RST = 8'd32;
    localparam logic [COUNT_W-1:0] MAX_PAYLOAD_RST = 9'd256;

    typedef struct packed {
        logic [BYTE_W-1:0]  start_code;
        logic [BYTE_W-1:0]  end_code;
        logic [BYTE_W-1:0]  escape_code;
        logic [BYTE_W-1:0]  escape_mask;
        logic [COUNT_W-1:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } item_t;

endpackage

[design/bsfd_byte_if.sv]
// ----------------------------------------------------------------------------
// bsfd_byte_if
// raw line byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bsfd_byte_if;

    logic                         valid;
    logic                         ready;
    logic [bsfd_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
    modport mon    (input valid, input in_byte, input ready);

endinterface

[design/bsfd_result_if.sv]
// ----------------------------------------------------------------------------
// bsfd_result_if
// decoded result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bsfd_result_if;

    logic                          valid;
    logic                          ready;
    logic [bsfd_pkg::BYTE_W-1:0]   out_byte;
    logic [bsfd_pkg::KIND_W-1:0]   kind;
    logic [bsfd_pkg::COUNT_W-1:0]  payload_count;

    modport source (output valid, output out_byte, output kind, output payload_count,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input payload_count,
                    output ready);
    modport mon    (input valid, input out_byte, input kind, input payload_count,
                    input ready);

endinterface

[design/bsfd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bsfd_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module bsfd_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bsfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bsfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output bsfd_pkg::cfg_t                      cfg
);

    bsfd_pkg::cfg_t cfg_reg;
    bsfd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                bsfd_pkg::REG_START_CODE:  cfg_next.start_code  = cfg_wdata[7:0];
                bsfd_pkg::REG_END_CODE:    cfg_next.end_code    = cfg_wdata[7:0];
                bsfd_pkg::REG_ESCAPE_CODE: cfg_next.escape_code = cfg_wdata[7:0];
                bsfd_pkg::REG_ESCAPE_MASK: cfg_next.escape_mask = cfg_wdata[7:0];
                bsfd_pkg::REG_MAX_PAYLOAD: cfg_next.max_payload = cfg_wdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code  <= bsfd_pkg::START_CODE_RST;
            cfg_reg.end_code    <= bsfd_pkg::END_CODE_RST;
            cfg_reg.escape_code <= bsfd_pkg::ESCAPE_CODE_RST;
            cfg_reg.escape_mask <= bsfd_pkg::ESCAPE_MASK_RST;
            cfg_reg.max_payload <= bsfd_pkg::MAX_PAYLOAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/bsfd_in_stage.sv]
// ----------------------------------------------------------------------------
// bsfd_in_stage
// input register in front of the decode stage
// ----------------------------------------------------------------------------
module bsfd_in_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    bsfd_byte_if.sink            in_ch,
    input  logic                 advance,
    output bsfd_pkg::item_t      item
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [bsfd_pkg::BYTE_W-1:0]  data_reg;
    logic                         take;

    // the register frees up whenever decode takes its byte this cycle
    assign in_ch.ready = !valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= in_ch.in_byte;
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

[design/bsfd_decode.sv]
// ----------------------------------------------------------------------------
// bsfd_decode
// frame state, unstuffing and checksum decision, result register
// ----------------------------------------------------------------------------
module bsfd_decode
#(
    parameter int unsigned MAX_PAYLOAD = bsfd_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bsfd_pkg::cfg_t       cfg,
    input  bsfd_pkg::item_t      item,
    output logic                 advance,
    bsfd_result_if.source        out_ch
);

    localparam int unsigned COUNT_MAX = (1 << bsfd_pkg::COUNT_W) - 1;
    localparam int unsigned LIM_CAP   = (MAX_PAYLOAD > COUNT_MAX) ? COUNT_MAX : MAX_PAYLOAD;

    logic                           in_frame_reg,   in_frame_next;
    logic                           held_valid_reg, held_valid_next;
    logic [bsfd_pkg::BYTE_W-1:0]    held_byte_reg,  held_byte_next;
    logic [bsfd_pkg::BYTE_W-1:0]    sum_reg,        sum_next;
    logic [bsfd_pkg::COUNT_W-1:0]   count_reg,      count_next;

    logic                           res_valid_reg,  res_valid_next;
    logic [bsfd_pkg::BYTE_W-1:0]    res_byte_reg,   res_byte_next;
    logic [bsfd_pkg::KIND_W-1:0]    res_kind_reg,   res_kind_next;
    logic [bsfd_pkg::COUNT_W-1:0]   res_count_reg,  res_count_next;

    logic [bsfd_pkg::COUNT_W-1:0]   limit;
    logic [bsfd_pkg::BYTE_W-1:0]    b;
    logic [bsfd_pkg::BYTE_W-1:0]    dval;
    logic                           emit;
    logic                           deliver;
    logic                           close;
    logic                           fire;

    assign advance = !res_valid_reg || out_ch.ready;
    assign fire    = item.valid && advance;
    assign b       = item.data;

    assign limit = (cfg.max_payload > bsfd_pkg::COUNT_W'(LIM_CAP))
                 ? bsfd_pkg::COUNT_W'(LIM_CAP) : cfg.max_payload;

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        held_valid_next = held_valid_reg;
        held_byte_next  = held_byte_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        emit            = 1'b0;
        deliver         = 1'b0;
        close           = 1'b0;
        dval            = held_byte_reg;
        res_kind_next   = bsfd_pkg::KIND_DATA;

        if (!in_frame_reg)
        begin
            if (b == cfg.start_code)
                in_frame_next = 1'b1;
        end
        else if (!held_valid_reg)
        begin
            held_byte_next  = b;
            held_valid_next = 1'b1;
        end
        else if (b == cfg.end_code)
        begin
            close         = 1'b1;
            res_kind_next = (held_byte_reg == sum_reg) ? bsfd_pkg::KIND_OK
                                                       : bsfd_pkg::KIND_CSUM;
        end
        else if (count_reg >= limit)
        begin
            close         = 1'b1;
            res_kind_next = bsfd_pkg::KIND_LONG;
        end
        else if (held_byte_reg == cfg.escape_code)
        begin
            if (b == cfg.start_code || b == cfg.escape_code)
            begin
                close         = 1'b1;
                res_kind_next = bsfd_pkg::KIND_PARSE;
            end
            else
            begin
                deliver         = 1'b1;
                dval            = b ^ cfg.escape_mask;
                held_valid_next = 1'b0;
                held_byte_next  = '0;
            end
        end
        else if (held_byte_reg == cfg.start_code)
        begin
            close         = 1'b1;
            res_kind_next = bsfd_pkg::KIND_PARSE;
        end
        else
        begin
            deliver        = 1'b1;
            dval           = held_byte_reg;
            held_byte_next = b;
        end

        res_byte_next  = '0;
        res_count_next = count_reg;

        if (deliver)
        begin
            emit           = 1'b1;
            sum_next       = sum_reg + dval;
            count_next     = count_reg + 1'b1;
            res_byte_next  = dval;
            res_count_next = count_next;
        end

        // any status result drops back to idle
        if (close)
        begin
            emit            = 1'b1;
            in_frame_next   = 1'b0;
            held_valid_next = 1'b0;
            held_byte_next  = '0;
            sum_next        = '0;
            count_next      = '0;
        end

        if (!fire)
        begin
            in_frame_next   = in_frame_reg;
            held_valid_next = held_valid_reg;
            held_byte_next  = held_byte_reg;
            sum_next        = sum_reg;
            count_next      = count_reg;
        end

        if (fire)
            res_valid_next = emit;
        else if (out_ch.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            res_byte_reg  <= res_byte_next;
            res_kind_reg  <= res_kind_next;
            res_count_reg <= res_count_next;
        end
    end

    assign out_ch.valid         = res_valid_reg;
    assign out_ch.out_byte      = res_byte_reg;
    assign out_ch.kind          = res_kind_reg;
    assign out_ch.payload_count = res_count_reg;

endmodule

[design/byte_stuffed_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// byte_stuffed_frame_decoder_core
// deframer for start/escape/checksum/end framed byte streams
//
//   channel  | direction | payload
//   ---------+-----------+-----------------------------------
//   in_ch    | sink      | in_byte
//   out_ch   | source    | out_byte, kind, payload_count
//   cfg      | write     | cfg_we, cfg_index, cfg_wdata
//
// one byte per cycle unless the result stalls; an accepted byte is loaded into the
// input register and then decoded into the result register
// frame state and the result register step together, so the only limit is
// the result register draining; a stalled result holds the input register
// reset clears frame state and loads the default codes
// ----------------------------------------------------------------------------
module byte_stuffed_frame_decoder_core
#(
    parameter int unsigned MAX_PAYLOAD = bsfd_pkg::MAX_PAYLOAD_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    bsfd_byte_if.sink                         in_ch,
    bsfd_result_if.source                     out_ch,
    input  logic                              cfg_we,
    input  logic [bsfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsfd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    bsfd_pkg::cfg_t   cfg;
    bsfd_pkg::item_t  item;
    logic             advance;

    bsfd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bsfd_in_stage u_in
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .advance (advance),
        .item    (item)
    );

    bsfd_decode
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_dec
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item),
        .advance (advance),
        .out_ch  (out_ch)
    );

endmodule

[design/bsfd_checker.sv]
// ----------------------------------------------------------------------------
// bsfd_checker
// port level checks on the frame decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "byte_stuffed_frame_decoder_core_macros.svh"

module bsfd_checker
(
    input  logic           clk,
    input  logic           rst_n,
    bsfd_byte_if.sink      in_ch,
    bsfd_result_if.source  out_ch
);

    // a held result keeps its payload until the transaction completes
    `BSFD_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.kind) && $stable(out_ch.out_byte) && $stable(out_ch.payload_count), "result changed while stalled")

    // data results always count at least one payload byte
    `BSFD_ASSERT_NOW(a_data_count, out_ch.valid && out_ch.kind == bsfd_pkg::KIND_DATA, out_ch.payload_count != '0, "data result with zero count")

    // status results carry no byte
    `BSFD_ASSERT_NOW(a_status_byte, out_ch.valid && out_ch.kind != bsfd_pkg::KIND_DATA, out_ch.out_byte == '0, "status result with nonzero byte")

    // input back-pressure only comes from a stalled result
    `BSFD_ASSERT_NOW(a_in_stall, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled without output stall")

endmodule

bind byte_stuffed_frame_decoder_core bsfd_checker u_bsfd_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
);

[dv/byte_stuffed_frame_decoder_core_test.sv]
// ----------------------------------------------------------------------------
// byte_stuffed_frame_decoder_core_test
// drives framed line bytes through the decoder under several code settings,
// predicts every payload byte and frame status, checks them in order
// ----------------------------------------------------------------------------
module byte_stuffed_frame_decoder_core_test;

    import bsfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 250;
    localparam int PHASE_BYTES    = 180;
    localparam int NUM_PHASES     = 7;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] payload_count;
    } decoded_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_CSUM,
        FLAW_BAD_ESCAPE,
        FLAW_STRAY_START,
        FLAW_NOISE
    } flaw_t;

    class frame_scoreboard;
        cfg_t               regs;
        logic               in_frame;
        logic               held_valid;
        logic [BYTE_W-1:0]  held_byte;
        logic [BYTE_W-1:0]  running_sum;
        logic [COUNT_W-1:0] byte_count;
        decoded_t           decoded_q[$];
        int                 fails;

        function new();
            regs.start_code  = START_CODE_RST;
            regs.end_code    = END_CODE_RST;
            regs.escape_code = ESCAPE_CODE_RST;
            regs.escape_mask = ESCAPE_MASK_RST;
            regs.max_payload = MAX_PAYLOAD_RST;
            fails = 0;
            go_idle();
        endfunction

        function void go_idle();
            in_frame    = 1'b0;
            held_valid  = 1'b0;
            held_byte   = '0;
            running_sum = '0;
            byte_count  = '0;
        endfunction

        function void write_reg(int idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_START_CODE:  regs.start_code  = val[BYTE_W-1:0];
                REG_END_CODE:    regs.end_code    = val[BYTE_W-1:0];
                REG_ESCAPE_CODE: regs.escape_code = val[BYTE_W-1:0];
                REG_ESCAPE_MASK: regs.escape_mask = val[BYTE_W-1:0];
                REG_MAX_PAYLOAD: regs.max_payload = val[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void close_frame(logic [KIND_W-1:0] k);
            decoded_t d;
            d.out_byte      = '0;
            d.kind          = k;
            d.payload_count = byte_count;
            decoded_q.push_back(d);
            go_idle();
        endfunction

        function void deliver(logic [BYTE_W-1:0] b);
            decoded_t d;
            running_sum = running_sum + b;
            byte_count  = byte_count + 1'b1;
            d.out_byte      = b;
            d.kind          = KIND_DATA;
            d.payload_count = byte_count;
            decoded_q.push_back(d);
        endfunction

        // one accepted line byte
        function void note_byte(logic [BYTE_W-1:0] b);
            int unsigned lim;
            logic [BYTE_W-1:0] h;
            lim = regs.max_payload;
            if (lim > MAX_PAYLOAD_DEF)
            begin
                lim = MAX_PAYLOAD_DEF;
            end
            if (!in_frame)
            begin
                if (b == regs.start_code)
                begin
                    go_idle();
                    in_frame = 1'b1;
                end
                return;
            end
            if (!held_valid)
            begin
                held_byte  = b;
                held_valid = 1'b1;
                return;
            end
            // held byte is the checksum once the end code shows up
            if (b == regs.end_code)
            begin
                close_frame((held_byte == running_sum) ? KIND_OK : KIND_CSUM);
                return;
            end
            if (byte_count >= lim)
            begin
                close_frame(KIND_LONG);
                return;
            end
            h = held_byte;
            if (h == regs.escape_code)
            begin
                if (b == regs.start_code || b == regs.escape_code)
                begin
                    close_frame(KIND_PARSE);
                    return;
                end
                held_valid = 1'b0;
                held_byte  = '0;
                deliver(b ^ regs.escape_mask);
                return;
            end
            if (h == regs.start_code)
            begin
                close_frame(KIND_PARSE);
                return;
            end
            held_byte = b;
            deliver(h);
        endfunction

        function void mismatch(string field, int exp_v, int act_v);
            fails++;
            $error("%s: expected %0d, actual %0d", field, exp_v, act_v);
        endfunction

        function void check_result(logic [BYTE_W-1:0] ob, logic [KIND_W-1:0] k,
                                   logic [COUNT_W-1:0] cnt);
            decoded_t e;
            if (decoded_q.size() == 0)
            begin
                fails++;
                $error("result with none pending: kind %0d out_byte %0d payload_count %0d",
                       k, ob, cnt);
                return;
            end
            e = decoded_q.pop_front();
            if (ob !== e.out_byte)
            begin
                mismatch("out_byte", e.out_byte, ob);
            end
            if (k !== e.kind)
            begin
                mismatch("kind", e.kind, k);
            end
            if (cnt !== e.payload_count)
            begin
                mismatch("payload_count", e.payload_count, cnt);
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bsfd_byte_if   in_ch();
    bsfd_result_if out_ch();

    byte_stuffed_frame_decoder_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    frame_scoreboard sb;
    cfg_t            gen_cfg;
    bit              idle_on = 1'b1;
    bit              stall_on = 1'b1;
    bit              hold_req = 1'b0;
    int              sent_count = 0;
    int              quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // transaction monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                sb.note_byte(in_ch.in_byte);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                sb.check_result(out_ch.out_byte, out_ch.kind, out_ch.payload_count);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result receiver: random stalls plus one long hold-off
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 6) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent_count++;
    endtask

    // wait until every predicted result is out, then let the pipeline settle
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input cfg_t c);
        logic [CFG_DATA_W-1:0] vals [0:4];
        vals[REG_START_CODE]  = {1'b0, c.start_code};
        vals[REG_END_CODE]    = {1'b0, c.end_code};
        vals[REG_ESCAPE_CODE] = {1'b0, c.escape_code};
        vals[REG_ESCAPE_MASK] = {1'b0, c.escape_mask};
        vals[REG_MAX_PAYLOAD] = c.max_payload;
        cfg_we <= 1'b1;
        for (int i = int'(REG_START_CODE); i <= int'(REG_MAX_PAYLOAD); i++)
        begin
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_wdata <= vals[i];
            @(posedge clk);
            sb.write_reg(i, vals[i]);
        end
        cfg_we  <= 1'b0;
        gen_cfg = c;
    endtask

    function automatic cfg_t phase_cfg(int ph);
        cfg_t c;
        case (ph)
            0: c = '{8'h7E, 8'h7F, 8'h7D, 8'h20, 9'd256};
            1: c = '{8'h00, 8'hFF, 8'h01, 8'hFF, 9'd8};
            2: c = '{8'hFF, 8'h00, 8'hFE, 8'h00, 9'd1};
            3: c = '{8'h55, 8'h55, 8'h55, 8'h80, 9'd0};
            4: c = '{8'hA5, 8'h5A, 8'h3C, 8'hC3, 9'd511};
            5:
            begin
                c.start_code  = 8'($urandom());
                c.end_code    = c.start_code + 8'($urandom_range(1, 80));
                c.escape_code = c.end_code + 8'($urandom_range(1, 80));
                c.escape_mask = 8'($urandom_range(1, 255));
                c.max_payload = 9'($urandom_range(1, 20));
            end
            default: c = '{START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST,
                           ESCAPE_MASK_RST, 9'd300};
        endcase
        return c;
    endfunction

    // encode one frame with the current codes, optionally damaged
    task automatic send_frame(input int len, input flaw_t flaw);
        logic [BYTE_W-1:0] line[$];
        logic [BYTE_W-1:0] p;
        logic [BYTE_W-1:0] sum;
        int pos;
        sum = '0;
        line.push_back(gen_cfg.start_code);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: p = gen_cfg.start_code;
                    1: p = gen_cfg.end_code;
                    default: p = gen_cfg.escape_code;
                endcase
            end
            else
            begin
                p = 8'($urandom());
            end
            if (p == gen_cfg.start_code || p == gen_cfg.end_code || p == gen_cfg.escape_code)
            begin
                line.push_back(gen_cfg.escape_code);
                line.push_back(p ^ gen_cfg.escape_mask);
            end
            else
            begin
                line.push_back(p);
            end
            sum = sum + p;
        end
        if (flaw == FLAW_CSUM)
        begin
            sum = sum + 8'($urandom_range(1, 255));
        end
        line.push_back(sum);
        line.push_back(gen_cfg.end_code);
        pos = $urandom_range(1, line.size() - 1);
        case (flaw)
            FLAW_BAD_ESCAPE:
            begin
                line.insert(pos, gen_cfg.escape_code);
                line.insert(pos + 1, $urandom_range(0, 1) ? gen_cfg.start_code
                                                          : gen_cfg.escape_code);
            end
            FLAW_STRAY_START: line.insert(pos, gen_cfg.start_code);
            FLAW_NOISE:       line[pos] = 8'($urandom());
            default: ;
        endcase
        foreach (line[i])
        begin
            send_byte(line[i]);
        end
    endtask

    task automatic random_frame();
        int len;
        int pick;
        flaw_t flaw;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom()));
        end
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 260) : $urandom_range(0, 12);
        pick = $urandom_range(0, 9);
        case (pick)
            6: flaw = FLAW_CSUM;
            7: flaw = FLAW_BAD_ESCAPE;
            8: flaw = FLAW_STRAY_START;
            9: flaw = FLAW_NOISE;
            default: flaw = FLAW_NONE;
        endcase
        send_frame(len, flaw);
    endtask

    initial
    begin
        logic [BYTE_W-1:0] directed[$];
        int phase_start;
        sb = new();
        gen_cfg = '{START_CODE_RST, END_CODE_RST, ESCAPE_CODE_RST,
                    ESCAPE_MASK_RST, MAX_PAYLOAD_RST};
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_wdata     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle drop, good frame with an escape, bad escapes, held start,
        // end code with nothing held, escape held as checksum
        directed = '{8'hFF,
                     8'h02, 8'h00, 8'hFF, 8'h1B, 8'h22, 8'h01, 8'h03,
                     8'h02, 8'h1B, 8'h02,
                     8'h02, 8'h1B, 8'h1B,
                     8'h02, 8'h05, 8'h02, 8'h07,
                     8'h02, 8'h03, 8'h03,
                     8'h02, 8'h1B, 8'h03};
        foreach (directed[i])
        begin
            send_byte(directed[i]);
        end
        wait_quiet();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_config(phase_cfg(ph));
            if (ph == 0)
            begin
                hold_req = 1'b1;
            end
            if (ph == NUM_PHASES - 1)
            begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_BYTES)
            begin
                random_frame();
            end
            wait_quiet();
        end

        repeat (10) @(posedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[byte_stuffed_frame_decoder_core.f]
+incdir+design
design/bsfd_pkg.sv
design/bsfd_byte_if.sv
design/bsfd_result_if.sv
design/bsfd_cfg_regs.sv
design/bsfd_in_stage.sv
design/bsfd_decode.sv
design/byte_stuffed_frame_decoder_core.sv
design/bsfd_checker.sv
dv/byte_stuffed_frame_decoder_core_test.sv
